// ----- sv/can_bus_traffic_monitor_unit_defines.svh -----
// Assertion helpers shared by the monitor modules.
`ifndef CAN_BUS_TRAFFIC_MONITOR_UNIT_DEFINES_SVH
`define CAN_BUS_TRAFFIC_MONITOR_UNIT_DEFINES_SVH

// same-cycle implication
`define CBTM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CBTM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/cbtm_pkg.sv -----
package cbtm_pkg;

	typedef struct packed {
		logic        kind;
		logic [28:0] frame_id;
		logic        extended;
		logic [3:0]  length;
		logic [31:0] now_ms;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  node_index;
		logic [4:0]  node_type;
		logic [7:0]  node_maker;
		logic [5:0]  node_number;
		logic [31:0] node_frames;
		logic [15:0] node_rate;
		logic        node_quiet;
		logic [15:0] bus_load;
		logic [31:0] total_frames;
		logic        heartbeat_alive;
		logic        last_of_run;
	} res_t;

	typedef struct packed {
		logic [4:0]  typ;
		logic [7:0]  maker;
		logic [5:0]  number;
		logic [31:0] frames;
		logic [15:0] window;
		logic [31:0] last;
		logic        quiet;
		logic [15:0] rate;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	localparam logic [2:0] ST_IGNORED = 3'd0;
	localparam logic [2:0] ST_BCAST   = 3'd1;
	localparam logic [2:0] ST_UPDATED = 3'd2;
	localparam logic [2:0] ST_ADDED   = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;
	localparam logic [2:0] ST_TICK    = 3'd5;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 29;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_RATE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUIET     = 2'd3;

	localparam logic [22:0] BIT_RATE_RST  = 23'd1000000;
	localparam logic [28:0] HEARTBEAT_RST = 29'h01011840;
	localparam logic [15:0] WINDOW_RST    = 16'd500;
	localparam logic [15:0] QUIET_RST     = 16'd1000;

	localparam logic [6:0] REPORT_CAP = 7'd32;

	localparam int NUM_W = 56;
	localparam int DEN_W = 55;
	localparam int QUO_W = 16;

	typedef struct packed {
		logic       latch;
		logic       frame_pre;
		logic       tick_pre;
		logic       load_mul;
		logic       rate_mul;
		logic       div_start;
		logic       load_upd;
		logic       idx_clr;
		logic       idx_inc;
		logic       ram_rd;
		logic       wr_hit;
		logic       wr_new;
		logic       wr_tick;
		logic       emit;
		logic [2:0] est;
	} cmd_t;

	typedef struct packed {
		logic kind;
		logic ext;
		logic bcast;
		logic cnt_zero;
		logic cnt_full;
		logic close;
		logic match;
		logic idx_last;
		logic div_done;
	} sts_t;

	// average halfway toward the new value; zero means no average yet
	function automatic logic [15:0] blend(input logic [15:0] avg, input logic [15:0] fresh);
		logic [16:0] s;
		s = 17'(avg) + 17'(fresh);
		return (avg == 16'd0) ? fresh : s[16:1];
	endfunction

	// wire bits of a frame with one fifth added for stuffing
	function automatic logic [7:0] wire_bits(input logic ext, input logic [3:0] len);
		logic [3:0]  l;
		logic [7:0]  raw;
		logic [15:0] p;
		l   = (len > 4'd8) ? 4'd8 : len;
		raw = (ext ? 8'd67 : 8'd47) + {1'b0, l, 3'b000};
		p   = 16'(raw) * 16'd205;  // raw/5 exact for raw below 160
		return raw + {2'b00, p[15:10]};
	endfunction

endpackage

// ----- sv/cbtm_ram.sv -----
module cbtm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ----- sv/cbtm_div.sv -----
// restoring divider, one quotient bit a cycle, quotient saturated to 16 bits
module cbtm_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [cbtm_pkg::NUM_W-1:0]   num,
	input  logic [cbtm_pkg::DEN_W-1:0]   den,
	output logic                         done,
	output logic [cbtm_pkg::QUO_W-1:0]   quo
);
	logic                        busy_q;
	logic [4:0]                  cnt_q;
	logic [cbtm_pkg::DEN_W-1:0]  rem_q;
	logic [cbtm_pkg::QUO_W-1:0]  low_q;
	logic                        done_q;
	logic [cbtm_pkg::DEN_W:0]    trial;
	logic [cbtm_pkg::DEN_W:0]    den_x;
	logic                        ge;
	logic [cbtm_pkg::DEN_W:0]    diff;
	logic                        sat;

	assign trial = {rem_q, low_q[cbtm_pkg::QUO_W-1]};
	assign den_x = {1'b0, den};
	assign ge    = trial >= den_x;
	assign diff  = trial - den_x;
	assign sat   = cbtm_pkg::DEN_W'(num[cbtm_pkg::NUM_W-1:cbtm_pkg::QUO_W]) >= den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (sat) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= 5'(cbtm_pkg::QUO_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= cbtm_pkg::DEN_W'(num[cbtm_pkg::NUM_W-1:cbtm_pkg::QUO_W]);
			low_q <= sat ? {cbtm_pkg::QUO_W{1'b1}} : num[cbtm_pkg::QUO_W-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[cbtm_pkg::DEN_W-1:0] : trial[cbtm_pkg::DEN_W-1:0];
			low_q <= {low_q[cbtm_pkg::QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = low_q;
endmodule

// ----- sv/cbtm_ctrl.sv -----
`include "can_bus_traffic_monitor_unit_defines.svh"

module cbtm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  cbtm_pkg::sts_t sts,
	output cbtm_pkg::cmd_t cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC  = 4'd1;
	localparam logic [3:0] S_FSEL = 4'd2;
	localparam logic [3:0] S_TSEL = 4'd3;
	localparam logic [3:0] S_LST  = 4'd4;
	localparam logic [3:0] S_LDIV = 4'd5;
	localparam logic [3:0] S_LEND = 4'd6;
	localparam logic [3:0] S_RD   = 4'd7;
	localparam logic [3:0] S_CHK  = 4'd8;
	localparam logic [3:0] S_RST  = 4'd9;
	localparam logic [3:0] S_RDIV = 4'd10;
	localparam logic [3:0] S_TWR  = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.kind) begin
					cmd.tick_pre = 1'b1;
					state_d      = S_TSEL;
				end else begin
					cmd.frame_pre = 1'b1;
					state_d       = S_FSEL;
				end
			end
			S_FSEL: begin
				if (!sts.ext) begin
					cmd.emit = 1'b1;
					cmd.est  = cbtm_pkg::ST_IGNORED;
					state_d  = S_IDLE;
				end else if (sts.bcast) begin
					cmd.emit = 1'b1;
					cmd.est  = cbtm_pkg::ST_BCAST;
					state_d  = S_IDLE;
				end else if (sts.cnt_zero) begin
					cmd.wr_new = 1'b1;
					cmd.emit   = 1'b1;
					cmd.est    = cbtm_pkg::ST_ADDED;
					state_d    = S_IDLE;
				end else begin
					cmd.idx_clr = 1'b1;
					state_d     = S_RD;
				end
			end
			S_TSEL: begin
				if (sts.close) begin
					cmd.load_mul = 1'b1;
					state_d      = S_LST;
				end else if (sts.cnt_zero) begin
					cmd.emit = 1'b1;
					cmd.est  = cbtm_pkg::ST_TICK;
					state_d  = S_IDLE;
				end else begin
					cmd.idx_clr = 1'b1;
					state_d     = S_RD;
				end
			end
			S_LST: begin
				cmd.div_start = 1'b1;
				state_d       = S_LDIV;
			end
			S_LDIV: begin
				if (sts.div_done) begin
					cmd.load_upd = 1'b1;
					state_d      = S_LEND;
				end
			end
			S_LEND: begin
				if (sts.cnt_zero) begin
					cmd.emit = 1'b1;
					cmd.est  = cbtm_pkg::ST_TICK;
					state_d  = S_IDLE;
				end else begin
					cmd.idx_clr = 1'b1;
					state_d     = S_RD;
				end
			end
			S_RD: begin
				cmd.ram_rd = 1'b1;
				state_d    = S_CHK;
			end
			S_CHK: begin
				if (sts.kind) begin
					if (sts.close) begin
						cmd.rate_mul = 1'b1;
						state_d      = S_RST;
					end else begin
						state_d = S_TWR;
					end
				end else if (sts.match) begin
					cmd.wr_hit = 1'b1;
					cmd.emit   = 1'b1;
					cmd.est    = cbtm_pkg::ST_UPDATED;
					state_d    = S_IDLE;
				end else if (!sts.idx_last) begin
					cmd.idx_inc = 1'b1;
					state_d     = S_RD;
				end else if (sts.cnt_full) begin
					cmd.emit = 1'b1;
					cmd.est  = cbtm_pkg::ST_FULL;
					state_d  = S_IDLE;
				end else begin
					cmd.wr_new = 1'b1;
					cmd.emit   = 1'b1;
					cmd.est    = cbtm_pkg::ST_ADDED;
					state_d    = S_IDLE;
				end
			end
			S_RST: begin
				cmd.div_start = 1'b1;
				state_d       = S_RDIV;
			end
			S_RDIV: begin
				if (sts.div_done) begin
					state_d = S_TWR;
				end
			end
			S_TWR: begin
				cmd.wr_tick = 1'b1;
				cmd.emit    = 1'b1;
				cmd.est     = cbtm_pkg::ST_TICK;
				if (sts.idx_last) begin
					state_d = S_IDLE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;

	`CBTM_ASSERT_NEXT(a_accept_decodes, start && (state_q == S_IDLE), state_q == S_DEC, "accepted request not decoded")
	`CBTM_ASSERT_NEXT(a_div_waits, cmd.div_start, (state_q == S_LDIV) || (state_q == S_RDIV), "divider started without wait")
	`CBTM_ASSERT_NEXT(a_emit_finishes, cmd.emit && (state_q != S_TWR), state_q == S_IDLE, "single result not followed by idle")
endmodule

// ----- sv/cbtm_dp.sv -----
`include "can_bus_traffic_monitor_unit_defines.svh"

module cbtm_dp #(
	parameter int MAX_NODES = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cbtm_pkg::req_t                    request,
	input  logic                              cfg_valid,
	input  logic [cbtm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cbtm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  cbtm_pkg::cmd_t                    cmd,
	output cbtm_pkg::sts_t                    sts,
	output logic                              res_valid,
	output cbtm_pkg::res_t                    result
);
	localparam int CNT_W = $clog2(MAX_NODES + 1);
	localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

	// configuration
	logic [22:0] br_q;
	logic [28:0] hb_q;
	logic [15:0] win_q;
	logic [15:0] qms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			br_q  <= cbtm_pkg::BIT_RATE_RST;
			hb_q  <= cbtm_pkg::HEARTBEAT_RST;
			win_q <= cbtm_pkg::WINDOW_RST;
			qms_q <= cbtm_pkg::QUIET_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				cbtm_pkg::REG_BIT_RATE:  br_q  <= cfg_data[22:0];
				cbtm_pkg::REG_HEARTBEAT: hb_q  <= cfg_data;
				cbtm_pkg::REG_WINDOW:    win_q <= cfg_data[15:0];
				cbtm_pkg::REG_QUIET:     qms_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	cbtm_pkg::req_t req_q;
	logic [31:0]    now;
	logic [4:0]     typ;
	logic [7:0]     maker;
	logic [5:0]     number;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= request;
		end
	end

	assign now    = req_q.now_ms;
	assign typ    = req_q.frame_id[28:24];
	assign maker  = req_q.frame_id[23:16];
	assign number = req_q.frame_id[5:0];

	// bus state
	logic [31:0]      ft_q;
	logic [31:0]      wb_q;
	logic [31:0]      wbeg_q;
	logic [15:0]      load_q;
	logic             beat_q;
	logic [31:0]      bt_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic [31:0]      span_q;
	logic             close_q;
	logic [7:0]       fbits;
	logic [32:0]      wb_sum;
	logic [31:0]      span_now;
	logic [31:0]      win_eff;
	logic [15:0]      quo;

	assign fbits    = cbtm_pkg::wire_bits(req_q.extended, req_q.length);
	assign wb_sum   = 33'(wb_q) + 33'(fbits);
	assign span_now = now - wbeg_q;
	assign win_eff  = (win_q == 16'd0) ? 32'd1 : 32'(win_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ft_q   <= '0;
			wb_q   <= '0;
			wbeg_q <= '0;
			load_q <= '0;
			beat_q <= 1'b0;
			bt_q   <= '0;
			cnt_q  <= '0;
			idx_q  <= '0;
		end else begin
			if (cmd.frame_pre) begin
				ft_q <= ft_q + 32'd1;
				wb_q <= wb_sum[32] ? 32'hffff_ffff : wb_sum[31:0];
				if (wbeg_q == 32'd0) begin
					wbeg_q <= now;
				end
				if (req_q.extended && (req_q.frame_id == hb_q)) begin
					beat_q <= 1'b1;
					bt_q   <= now;
				end
			end
			if (cmd.tick_pre) begin
				if (beat_q && (now >= bt_q) && ((now - bt_q) > 32'(qms_q))) begin
					beat_q <= 1'b0;
				end
			end
			if (cmd.load_upd) begin
				load_q <= cbtm_pkg::blend(load_q, quo);
				wb_q   <= '0;
				wbeg_q <= now;
			end
			if (cmd.wr_new) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick_pre) begin
			span_q  <= span_now;
			close_q <= (wbeg_q != 32'd0) && (now >= wbeg_q) && (span_now >= win_eff);
		end
	end

	// divider operands, products registered ahead of the divider
	logic [cbtm_pkg::NUM_W-1:0] num_q;
	logic [cbtm_pkg::DEN_W-1:0] den_q;
	logic [22:0]                br_eff;
	logic                       div_done;

	assign br_eff = (br_q == 23'd0) ? 23'd1 : br_q;

	// slot table
	cbtm_pkg::slot_t                rd_slot;
	cbtm_pkg::slot_t                wr_slot;
	logic [cbtm_pkg::SLOT_W-1:0]    ram_rdata;
	logic                           ram_we;
	logic [IDX_W-1:0]               ram_waddr;

	assign rd_slot = cbtm_pkg::slot_t'(ram_rdata);

	always_ff @(posedge clk) begin
		if (cmd.load_mul) begin
			num_q <= {42'(42'(wb_q) * 42'd1000), 14'd0};
			den_q <= cbtm_pkg::DEN_W'(cbtm_pkg::DEN_W'(span_q) * cbtm_pkg::DEN_W'(br_eff));
		end else if (cmd.rate_mul) begin
			num_q <= cbtm_pkg::NUM_W'(30'(30'(rd_slot.window) * 30'd16000));
			den_q <= cbtm_pkg::DEN_W'(span_q);
		end
	end

	cbtm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quo    (quo)
	);

	logic        new_quiet;
	logic [15:0] new_rate;
	logic [15:0] rate_mix;

	assign new_quiet = (now >= rd_slot.last) && ((now - rd_slot.last) > 32'(qms_q));
	assign rate_mix  = close_q ? cbtm_pkg::blend(rd_slot.rate, quo) : rd_slot.rate;
	assign new_rate  = new_quiet ? 16'd0 : rate_mix;

	always_comb begin
		wr_slot = rd_slot;
		if (cmd.wr_new) begin
			wr_slot.typ    = typ;
			wr_slot.maker  = maker;
			wr_slot.number = number;
			wr_slot.frames = 32'd1;
			wr_slot.window = 16'd1;
			wr_slot.last   = now;
			wr_slot.quiet  = 1'b0;
			wr_slot.rate   = 16'd0;
		end else if (cmd.wr_hit) begin
			wr_slot.frames = rd_slot.frames + 32'd1;
			if (rd_slot.window != 16'hffff) begin
				wr_slot.window = rd_slot.window + 16'd1;
			end
			wr_slot.last  = now;
			wr_slot.quiet = 1'b0;
		end else begin
			if (close_q) begin
				wr_slot.window = 16'd0;
			end
			wr_slot.quiet = new_quiet;
			wr_slot.rate  = new_rate;
		end
	end

	assign ram_we    = cmd.wr_new || cmd.wr_hit || cmd.wr_tick;
	assign ram_waddr = cmd.wr_new ? IDX_W'(cnt_q) : idx_q;

	cbtm_ram #(
		.WIDTH (cbtm_pkg::SLOT_W),
		.DEPTH (MAX_NODES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_slot),
		.re    (cmd.ram_rd),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// status
	logic [CNT_W-1:0] idx_ext;
	logic [6:0]       idx7;
	logic [6:0]       cnt7;
	logic             tick_last;
	logic             emit_ok;

	assign idx_ext = CNT_W'(idx_q);
	assign idx7    = 7'(idx_q);
	assign cnt7    = 7'(cnt_q);

	always_comb begin
		sts.kind     = req_q.kind;
		sts.ext      = req_q.extended;
		sts.bcast    = (typ == 5'd0) && (maker == 8'd0);
		sts.cnt_zero = cnt_q == '0;
		sts.cnt_full = cnt_q >= CNT_W'(MAX_NODES);
		sts.close    = close_q;
		sts.match    = (rd_slot.typ == typ) && (rd_slot.maker == maker)
			&& (rd_slot.number == number);
		sts.idx_last = (idx_ext + CNT_W'(1)) == cnt_q;
		sts.div_done = div_done;
	end

	// only the first slots up to the report cap show on a tick
	assign tick_last = (cnt7 > cbtm_pkg::REPORT_CAP) ? (idx7 == (cbtm_pkg::REPORT_CAP - 7'd1))
		: ((idx7 + 7'd1) == cnt7);
	assign emit_ok   = cmd.emit && (!cmd.wr_tick || (idx7 < cbtm_pkg::REPORT_CAP));

	cbtm_pkg::res_t res_d;
	cbtm_pkg::res_t res_q;
	logic           res_valid_q;

	always_comb begin
		res_d                 = '0;
		res_d.status          = cmd.est;
		res_d.bus_load        = load_q;
		res_d.total_frames    = ft_q;
		res_d.heartbeat_alive = beat_q;
		res_d.last_of_run     = 1'b1;
		case (cmd.est)
			cbtm_pkg::ST_BCAST, cbtm_pkg::ST_FULL: begin
				res_d.node_type   = typ;
				res_d.node_maker  = maker;
				res_d.node_number = number;
			end
			cbtm_pkg::ST_UPDATED: begin
				res_d.node_index  = 5'(idx_q);
				res_d.node_type   = typ;
				res_d.node_maker  = maker;
				res_d.node_number = number;
				res_d.node_frames = rd_slot.frames + 32'd1;
				res_d.node_rate   = rd_slot.rate;
			end
			cbtm_pkg::ST_ADDED: begin
				res_d.node_index  = 5'(cnt_q);
				res_d.node_type   = typ;
				res_d.node_maker  = maker;
				res_d.node_number = number;
				res_d.node_frames = 32'd1;
			end
			cbtm_pkg::ST_TICK: begin
				if (cmd.wr_tick) begin
					res_d.node_index  = 5'(idx_q);
					res_d.node_type   = rd_slot.typ;
					res_d.node_maker  = rd_slot.maker;
					res_d.node_number = rd_slot.number;
					res_d.node_frames = rd_slot.frames;
					res_d.node_rate   = new_rate;
					res_d.node_quiet  = new_quiet;
					res_d.last_of_run = tick_last;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= emit_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_ok) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign result    = res_q;

	`CBTM_ASSERT_NOW(a_rd_in_table, cmd.ram_rd, idx_ext < cnt_q, "slot read beyond node count")
	`CBTM_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(MAX_NODES), "node count above table size")
	`CBTM_ASSERT_NOW(a_new_has_room, cmd.wr_new, cnt_q < CNT_W'(MAX_NODES), "node added to full table")
endmodule

// ----- sv/can_bus_traffic_monitor_unit.sv -----
// Channel    Handshake                 Payload
// request    start / busy              request (req_t): kind, id, ext, length, now_ms
// result     res_valid (strobe)        result (res_t): status, node fields, bus totals
// config     cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A request is taken when start is high and busy low; one request is in work at a time.
// A frame is decoded and then searches the slot table one slot at a time. A tick
// visits every node in turn; a closing window adds the load division first and a rate
// division per node, and a saturating quotient cuts the divider wait short.
// Each result is a single-cycle strobe; the receiver cannot stall them.
// Reset clears counters, averages and node count; the slot table needs no clearing pass.
module can_bus_traffic_monitor_unit #(
	parameter int MAX_NODES = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  cbtm_pkg::req_t                  request,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cbtm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cbtm_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                            res_valid,
	output cbtm_pkg::res_t                  result
);
	cbtm_pkg::cmd_t cmd;
	cbtm_pkg::sts_t sts;

	// registers are writable at any time
	assign cfg_ready = 1'b1;

	// sequencer: decode, table walk, divider waits
	cbtm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	// state, slot RAM, shared divider and result register
	cbtm_dp #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (res_valid),
		.result    (result)
	);
endmodule

// ----- tb/sv/tb.sv -----
// Self-checking bench for the CAN bus traffic monitor.
// A queue of pending requests feeds a clocked driver; each accepted request is run
// through the local traffic predictor, which pushes the results it expects.
// A clocked monitor takes every result strobe and compares it field by field
// with the oldest expected result.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODE_CAP   = 32;
	localparam int CYCLE_CAP  = 3000000;
	localparam int DRAIN_WAIT = 1000;  // tick with a closing window and a full table

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	cbtm_pkg::req_t request = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [cbtm_pkg::CFG_IDX_W-1:0] cfg_index = cbtm_pkg::REG_BIT_RATE;
	logic [cbtm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic res_valid;
	cbtm_pkg::res_t result;

	// request traffic and checking state
	cbtm_pkg::req_t pending_reqs[$];
	cbtm_pkg::res_t expected_results[$];
	int unsigned errors = 0;
	int unsigned cycles = 0;
	bit calm = 1'b0;  // no driver idling while set

	// predictor copy of the configuration
	logic [22:0] p_bit_rate;
	logic [28:0] p_beat_id;
	logic [15:0] p_window_ms;
	logic [15:0] p_quiet_ms;

	// predictor copy of the block state
	logic [31:0] p_frames, p_win_bits, p_win_begin, p_beat_time;
	logic [15:0] p_load;
	logic p_beat;
	int p_nodes;
	cbtm_pkg::slot_t p_slot[NODE_CAP];

	// stimulus helpers
	logic [31:0] now_t;
	logic [18:0] node_keys[$];  // {type, maker, number}

	always #10 clk = ~clk;

	can_bus_traffic_monitor_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .res_valid(res_valid), .result(result)
	);

	function automatic cbtm_pkg::res_t make_result(logic [2:0] st, logic [4:0] idx,
			logic [4:0] typ, logic [7:0] maker, logic [5:0] num, logic [31:0] fr,
			logic [15:0] rate, logic quiet, logic last);
		cbtm_pkg::res_t r;
		r.status = st;
		r.node_index = idx;
		r.node_type = typ;
		r.node_maker = maker;
		r.node_number = num;
		r.node_frames = fr;
		r.node_rate = rate;
		r.node_quiet = quiet;
		r.bus_load = p_load;
		r.total_frames = p_frames;
		r.heartbeat_alive = p_beat;
		r.last_of_run = last;
		return r;
	endfunction

	function automatic logic [15:0] avg_toward(logic [15:0] avg, logic [15:0] fresh);
		logic [16:0] s;
		s = {1'b0, avg} + {1'b0, fresh};
		return (avg == 16'd0) ? fresh : s[16:1];
	endfunction

	function automatic logic [15:0] clip16(logic [63:0] v);
		return (v > 64'd65535) ? 16'hffff : v[15:0];
	endfunction

	// frame: count it, add its wire bits, then classify and track the node
	function automatic void predict_frame(cbtm_pkg::req_t q);
		logic [31:0] len, raw, bits;
		logic [4:0] typ;
		logic [7:0] maker;
		logic [5:0] num;
		int i;
		p_frames++;
		len = (q.length > 4'd8) ? 32'd8 : 32'(q.length);
		raw = (q.extended ? 32'd67 : 32'd47) + 32'd8 * len;
		bits = raw + raw / 32'd5;
		p_win_bits = (p_win_bits > 32'hffffffff - bits) ? 32'hffffffff : p_win_bits + bits;
		if (p_win_begin == 32'd0)
			p_win_begin = q.now_ms;
		if (!q.extended) begin
			expected_results.push_back(make_result(cbtm_pkg::ST_IGNORED, '0, '0, '0, '0,
				'0, '0, 1'b0, 1'b1));
			return;
		end
		if (q.frame_id == p_beat_id) begin
			p_beat = 1'b1;
			p_beat_time = q.now_ms;
		end
		typ = q.frame_id[28:24];
		maker = q.frame_id[23:16];
		num = q.frame_id[5:0];
		if (typ == 5'd0 && maker == 8'd0) begin
			expected_results.push_back(make_result(cbtm_pkg::ST_BCAST, '0, typ, maker, num,
				'0, '0, 1'b0, 1'b1));
			return;
		end
		for (i = 0; i < p_nodes; i++) begin
			if (p_slot[i].typ == typ && p_slot[i].maker == maker && p_slot[i].number == num) begin
				p_slot[i].frames++;
				if (p_slot[i].window != 16'hffff)
					p_slot[i].window++;
				p_slot[i].last = q.now_ms;
				p_slot[i].quiet = 1'b0;
				expected_results.push_back(make_result(cbtm_pkg::ST_UPDATED, 5'(i), typ, maker,
					num, p_slot[i].frames, p_slot[i].rate, 1'b0, 1'b1));
				return;
			end
		end
		if (p_nodes >= NODE_CAP) begin
			expected_results.push_back(make_result(cbtm_pkg::ST_FULL, '0, typ, maker, num,
				'0, '0, 1'b0, 1'b1));
			return;
		end
		p_slot[p_nodes] = '{typ: typ, maker: maker, number: num, frames: 32'd1, window: 16'd1,
			last: q.now_ms, quiet: 1'b0, rate: 16'd0};
		expected_results.push_back(make_result(cbtm_pkg::ST_ADDED, 5'(p_nodes), typ, maker, num,
			32'd1, '0, 1'b0, 1'b1));
		p_nodes++;
	endfunction

	// tick: close the window if due, age the nodes and the heartbeat, report the table
	function automatic void predict_tick(cbtm_pkg::req_t q);
		logic [31:0] now, win;
		logic [63:0] span, rdiv, numer;
		int i;
		now = q.now_ms;
		win = (p_window_ms == 16'd0) ? 32'd1 : 32'(p_window_ms);
		rdiv = (p_bit_rate == 23'd0) ? 64'd1 : 64'(p_bit_rate);
		if (p_win_begin != 32'd0 && now >= p_win_begin && now - p_win_begin >= win) begin
			span = 64'(now - p_win_begin);
			numer = 64'(p_win_bits) * 64'd1000 * 64'd16384;
			p_load = avg_toward(p_load, clip16(numer / (span * rdiv)));
			for (i = 0; i < p_nodes; i++) begin
				p_slot[i].rate = avg_toward(p_slot[i].rate,
					clip16(64'(p_slot[i].window) * 64'd16000 / span));
				p_slot[i].window = 16'd0;
			end
			p_win_bits = 32'd0;
			p_win_begin = now;
		end
		for (i = 0; i < p_nodes; i++) begin
			p_slot[i].quiet = (now >= p_slot[i].last) &&
				(now - p_slot[i].last > 32'(p_quiet_ms));
			if (p_slot[i].quiet)
				p_slot[i].rate = 16'd0;
		end
		if (p_beat && now >= p_beat_time && now - p_beat_time > 32'(p_quiet_ms))
			p_beat = 1'b0;
		if (p_nodes == 0) begin
			expected_results.push_back(make_result(cbtm_pkg::ST_TICK, '0, '0, '0, '0, '0, '0,
				1'b0, 1'b1));
			return;
		end
		for (i = 0; i < p_nodes; i++)
			expected_results.push_back(make_result(cbtm_pkg::ST_TICK, 5'(i), p_slot[i].typ,
				p_slot[i].maker, p_slot[i].number, p_slot[i].frames, p_slot[i].rate,
				p_slot[i].quiet, i == p_nodes - 1));
	endfunction

	// driver: takes the accepted request into the predictor, then offers the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				if (request.kind)
					predict_tick(request);
				else
					predict_frame(request);
			end
			if (!start || !busy) begin
				if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 21)) begin
					start <= 1'b1;
					request <= pending_reqs.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
			errors++;
		end
	endfunction

	// monitor: every strobe must match the oldest expected result
	always @(posedge clk) begin
		if (arst_n && res_valid) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $realtime, result);
				errors++;
			end else begin
				cbtm_pkg::res_t e;
				e = expected_results.pop_front();
				check_field("status", 32'(e.status), 32'(result.status));
				check_field("node_index", 32'(e.node_index), 32'(result.node_index));
				check_field("node_type", 32'(e.node_type), 32'(result.node_type));
				check_field("node_maker", 32'(e.node_maker), 32'(result.node_maker));
				check_field("node_number", 32'(e.node_number), 32'(result.node_number));
				check_field("node_frames", e.node_frames, result.node_frames);
				check_field("node_rate", 32'(e.node_rate), 32'(result.node_rate));
				check_field("node_quiet", 32'(e.node_quiet), 32'(result.node_quiet));
				check_field("bus_load", 32'(e.bus_load), 32'(result.bus_load));
				check_field("total_frames", e.total_frames, result.total_frames);
				check_field("heartbeat_alive", 32'(e.heartbeat_alive),
					32'(result.heartbeat_alive));
				check_field("last_of_run", 32'(e.last_of_run), 32'(result.last_of_run));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	function automatic void push_req(logic kind, logic [28:0] id, logic ext, logic [3:0] len,
			logic [31:0] now);
		cbtm_pkg::req_t q;
		q.kind = kind;
		q.frame_id = id;
		q.extended = ext;
		q.length = len;
		q.now_ms = now;
		pending_reqs.push_back(q);
	endfunction

	// one random request: mostly known nodes, some new nodes, broadcasts, standard
	// frames, heartbeats and ticks; time mostly moves forward, sometimes back
	function automatic void push_random();
		int pick;
		logic [18:0] k;
		logic [28:0] id;
		pick = $urandom_range(99);
		if ($urandom_range(99) < 4 && now_t > 32'd3000)
			now_t -= $urandom_range(2000);
		else
			now_t += $urandom_range(120);
		id = 29'($urandom);
		if (pick < 15) begin
			push_req(1'b1, id, 1'($urandom), 4'($urandom), now_t);
			return;
		end
		if (pick < 25) begin
			push_req(1'b0, id, 1'b0, 4'($urandom), now_t);
			return;
		end
		if (pick < 32)
			id[28:16] = 13'd0;  // broadcast
		else if (pick < 38)
			id = p_beat_id;
		else if (pick < 50 || node_keys.size() == 0) begin
			k = 19'($urandom);
			node_keys.push_back(k);
			{id[28:24], id[23:16], id[5:0]} = k;
		end else begin
			k = node_keys[$urandom_range(node_keys.size() - 1)];
			{id[28:24], id[23:16], id[5:0]} = k;
		end
		push_req(1'b0, id, 1'b1, 4'($urandom), now_t);
	endfunction

	// all requests accepted, all results in, then a quiet spell
	task automatic drain();
		while (pending_reqs.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [cbtm_pkg::CFG_IDX_W-1:0] idx,
			logic [cbtm_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			cbtm_pkg::REG_BIT_RATE:  p_bit_rate = val[22:0];
			cbtm_pkg::REG_HEARTBEAT: p_beat_id = val;
			cbtm_pkg::REG_WINDOW:    p_window_ms = val[15:0];
			default:                 p_quiet_ms = val[15:0];
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(int n);
		repeat (n) push_random();
		drain();
	endtask

	initial begin
		p_bit_rate = cbtm_pkg::BIT_RATE_RST;
		p_beat_id = cbtm_pkg::HEARTBEAT_RST;
		p_window_ms = cbtm_pkg::WINDOW_RST;
		p_quiet_ms = cbtm_pkg::QUIET_RST;
		p_frames = '0;
		p_win_bits = '0;
		p_win_begin = '0;
		p_beat_time = '0;
		p_load = '0;
		p_beat = 1'b0;
		p_nodes = 0;
		now_t = 32'd1000;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-table tick, unset time, length extremes, broadcast,
		// heartbeat, decode extremes, node update, window close, time going back
		push_req(1'b1, 29'd0, 1'b0, 4'd0, 32'd0);
		push_req(1'b0, 29'h7ff, 1'b0, 4'd0, 32'd0);
		push_req(1'b0, 29'h1fffffff, 1'b0, 4'd15, 32'd10);
		push_req(1'b0, 29'd0, 1'b1, 4'd8, 32'd20);
		push_req(1'b0, 29'h0000ffff, 1'b1, 4'd9, 32'd30);
		push_req(1'b0, cbtm_pkg::HEARTBEAT_RST, 1'b1, 4'd8, 32'd40);
		push_req(1'b0, 29'h1fffffff, 1'b1, 4'd8, 32'd50);
		push_req(1'b0, 29'h1fff003f, 1'b1, 4'd0, 32'd60);
		push_req(1'b0, 29'h01000000, 1'b1, 4'd1, 32'd70);
		push_req(1'b0, 29'h00010000, 1'b1, 4'd2, 32'd80);
		push_req(1'b1, 29'd0, 1'b0, 4'd0, 32'd100);
		push_req(1'b1, 29'd0, 1'b0, 4'd0, 32'd600);
		push_req(1'b0, 29'h1fffffff, 1'b1, 4'd8, 32'd700);
		push_req(1'b1, 29'd0, 1'b0, 4'd0, 32'd1300);
		push_req(1'b1, 29'd0, 1'b0, 4'd0, 32'd900);
		push_req(1'b1, 29'd0, 1'b0, 4'd0, 32'd2500);
		push_req(1'b0, cbtm_pkg::HEARTBEAT_RST, 1'b1, 4'd3, 32'd2600);
		push_req(1'b1, 29'd0, 1'b0, 4'd0, 32'd3200);
		now_t = 32'd3200;
		drain();

		// tightest settings: a tick closes a window whenever time has moved on, load saturates
		write_reg(cbtm_pkg::REG_BIT_RATE, 29'd1);
		write_reg(cbtm_pkg::REG_HEARTBEAT, 29'($urandom));
		write_reg(cbtm_pkg::REG_WINDOW, 29'd1);
		write_reg(cbtm_pkg::REG_QUIET, 29'd1);
		random_phase(100);

		// widest settings, no driver idling
		calm = 1'b1;
		write_reg(cbtm_pkg::REG_BIT_RATE, 29'd8000000);
		write_reg(cbtm_pkg::REG_HEARTBEAT, 29'h1fffffff);
		write_reg(cbtm_pkg::REG_WINDOW, 29'd65535);
		write_reg(cbtm_pkg::REG_QUIET, 29'd65535);
		random_phase(100);
		calm = 1'b0;

		// random mid-range settings
		write_reg(cbtm_pkg::REG_BIT_RATE, 29'($urandom_range(8000000, 1)));
		write_reg(cbtm_pkg::REG_HEARTBEAT, 29'd0);
		write_reg(cbtm_pkg::REG_WINDOW, 29'($urandom_range(800, 1)));
		write_reg(cbtm_pkg::REG_QUIET, 29'($urandom_range(3000, 1)));
		random_phase(100);

		// high clock values to exercise the upper time bits
		write_reg(cbtm_pkg::REG_BIT_RATE, 29'(cbtm_pkg::BIT_RATE_RST));
		write_reg(cbtm_pkg::REG_HEARTBEAT, cbtm_pkg::HEARTBEAT_RST);
		write_reg(cbtm_pkg::REG_WINDOW, 29'd200);
		write_reg(cbtm_pkg::REG_QUIET, 29'd500);
		now_t = 32'hfffe0000;
		random_phase(100);

		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/cbtm_pkg.sv
sv/cbtm_ram.sv
sv/cbtm_div.sv
sv/cbtm_ctrl.sv
sv/cbtm_dp.sv
sv/can_bus_traffic_monitor_unit.sv
tb/sv/tb.sv
